>>> design/mqf_pkg.sv
// ----------------------------------------------------------------------------
// mqf_pkg: shared types and constants of the multi-queue FIFO
// Field widths, request, result and status codes, parameter defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mqf_pkg;

	localparam int NUM_QUEUES_DEF  = 16;
	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int ITEM_BITS_DEF   = 16;

	localparam int REQ_W  = 2;
	localparam int QIDX_W = 4;
	localparam int ID_W   = 16;
	localparam int KIND_W = 3;
	localparam int STAT_W = 2;
	localparam int REM_W  = 7;

	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 32;

	typedef enum logic [REQ_W-1:0] {
		REQ_ENQ    = 2'd0,
		REQ_REWIND = 2'd1,
		REQ_STEP   = 2'd2,
		REQ_ROUND  = 2'd3
	} req_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ENQ    = 3'd0,
		KIND_REWIND = 3'd1,
		KIND_CURSOR = 3'd2,
		KIND_SERVED = 3'd3,
		KIND_EMPTY  = 3'd4
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_BAD_INDEX = 2'd1,
		STAT_NO_ROOM   = 2'd2
	} stat_t;

endpackage

>>> design/mqf_ram.sv
// ----------------------------------------------------------------------------
// mqf_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mqf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/multi_queue_fifo_service_round.sv
// ----------------------------------------------------------------------------
// multi_queue_fifo_service_round: bank of FIFO queues with cursors and rounds
// Enqueue, rewind and step on an ended cursor read the queue-state RAM, then register
// the result; a step onto an item also reads the item RAM first; one request at a time.
// A service round scans the queue-state RAM in order from queue 0 up.
// Async reset clears all queues and cursors at once via per-queue valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_queue_fifo_service_round #(
	parameter int NUM_QUEUES  = mqf_pkg::NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH = mqf_pkg::QUEUE_DEPTH_DEF,
	parameter int ITEM_BITS   = mqf_pkg::ITEM_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// queue_index[3:0], item_id[19:4], zero pad
	input  logic [mqf_pkg::S_TDATA_W-1:0] s_tdata,
	// req_type[1:0]
	input  logic [mqf_pkg::REQ_W-1:0]     s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status[1:0], queue_number[5:2], item_out[21:6], remaining[28:22],
	// has_next[29], zero pad
	output logic [mqf_pkg::M_TDATA_W-1:0] m_tdata,
	// result_kind[2:0]
	output logic [mqf_pkg::KIND_W-1:0]    m_tuser,
	output logic                          m_tlast
);

	import mqf_pkg::*;

	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SD = NUM_QUEUES * QUEUE_DEPTH;
	localparam int AW = $clog2(SD);
	localparam int MW = 2 * PW + CW + 1;

	// head, count, cursor offset, cursor ended
	localparam logic [MW-1:0] META_RST = {{(MW-1){1'b0}}, 1'b1};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BAD,
		ST_META,
		ST_STEP,
		ST_RMETA,
		ST_RITEM,
		ST_REND
	} state_t;

	function automatic logic [REM_W-1:0] to_rem(input logic [CW-1:0] c);
		logic [CW+REM_W-1:0] w;
		w = {{REM_W{1'b0}}, c};
		return w[REM_W-1:0];
	endfunction

	function automatic logic [QIDX_W-1:0] to_qn(input logic [QW-1:0] c);
		logic [QW+QIDX_W-1:0] w;
		w = {{QIDX_W{1'b0}}, c};
		return w[QIDX_W-1:0];
	endfunction

	function automatic logic [ID_W-1:0] to_id(input logic [ITEM_BITS-1:0] c);
		logic [ITEM_BITS+ID_W-1:0] w;
		w = {{ID_W{1'b0}}, c};
		return w[ID_W-1:0];
	endfunction

	state_t                 state_q;
	req_t                   req_q;
	logic [QIDX_W-1:0]      qidx_q;
	logic [ID_W-1:0]        item_q;
	logic [QW-1:0]          cur_q_q;
	logic [NUM_QUEUES-1:0]  vld_q;
	logic [REM_W-1:0]       nx_rem_q;
	logic                   nx_hn_q;
	logic                   pd_valid_q;
	logic [QIDX_W-1:0]      pd_qn_q;
	logic [ID_W-1:0]        pd_item_q;
	logic [REM_W-1:0]       pd_rem_q;
	logic                   pd_hn_q;
	logic                   m_tvalid_q;
	kind_t                  o_kind_q;
	stat_t                  o_stat_q;
	logic [QIDX_W-1:0]      o_qn_q;
	logic [ID_W-1:0]        o_item_q;
	logic [REM_W-1:0]       o_rem_q;
	logic                   o_hn_q;
	logic                   o_last_q;

	logic                   s_accept;
	logic                   out_free;
	req_t                   req_in;
	logic [QIDX_W-1:0]      qidx_in;
	logic [QW-1:0]          qidx_tr;
	logic                   bad_in;
	logic                   last_queue;

	logic [MW-1:0]          meta_rdata;
	logic [MW-1:0]          eff;
	logic [PW-1:0]          m_head;
	logic [CW-1:0]          m_cnt;
	logic [PW-1:0]          m_off;
	logic                   m_end;
	logic [PW-1:0]          nm_head;
	logic [CW-1:0]          nm_cnt;
	logic [PW-1:0]          nm_off;
	logic                   nm_end;
	logic                   meta_we;
	logic                   meta_re;
	logic [QW-1:0]          meta_raddr;

	logic [PW-1:0]          slot_off;
	logic [PW:0]            slot_sum;
	logic [PW-1:0]          slot;
	logic [PW-1:0]          head_inc;
	logic                   full;
	logic [CW-1:0]          cnt_inc;
	logic [CW-1:0]          cnt_dec;
	logic                   step_last;
	logic                   pop_end;
	logic [AW-1:0]          st_addr;
	logic                   st_we;
	logic                   st_re;
	logic [ITEM_BITS-1:0]   st_wdata;
	logic [ITEM_BITS-1:0]   st_rdata;
	logic [ITEM_BITS+ID_W-1:0] id_wide;

	logic                   out_push;
	kind_t                  op_kind;
	stat_t                  op_stat;
	logic [QIDX_W-1:0]      op_qn;
	logic [ID_W-1:0]        op_item;
	logic [REM_W-1:0]       op_rem;
	logic                   op_hn;
	logic                   op_last;
	logic                   ritem_go;

	assign s_tready   = (state_q == ST_IDLE);
	assign s_accept   = s_tvalid && s_tready;
	assign out_free   = !m_tvalid_q || m_tready;
	assign req_in     = req_t'(s_tuser);
	assign qidx_in    = s_tdata[QIDX_W-1:0];
	assign bad_in     = (32'(qidx_in) >= NUM_QUEUES);
	assign last_queue = (cur_q_q == QW'(NUM_QUEUES - 1));
	assign ritem_go   = !pd_valid_q || out_free;

	always_comb begin
		logic [QW+QIDX_W-1:0] qw;
		qw = {{QW{1'b0}}, qidx_in};
		qidx_tr = qw[QW-1:0];
	end

	// per-queue state; an entry never written reads as the reset value
	assign eff = vld_q[cur_q_q] ? meta_rdata : META_RST;
	assign {m_head, m_cnt, m_off, m_end} = eff;

	always_comb begin
		case (req_q)
			REQ_ENQ:  slot_off = m_cnt[PW-1:0];
			REQ_STEP: slot_off = m_off;
			default:  slot_off = '0;
		endcase
	end

	assign slot_sum  = {1'b0, m_head} + {1'b0, slot_off};
	assign slot      = (slot_sum >= (PW+1)'(QUEUE_DEPTH)) ?
	                   PW'(slot_sum - (PW+1)'(QUEUE_DEPTH)) : slot_sum[PW-1:0];
	assign head_inc  = (m_head == PW'(QUEUE_DEPTH - 1)) ? '0 : m_head + PW'(1);
	assign full      = (m_cnt >= CW'(QUEUE_DEPTH));
	assign cnt_inc   = m_cnt + CW'(1);
	assign cnt_dec   = m_cnt - CW'(1);
	assign step_last = ((CW'(m_off) + CW'(1)) >= m_cnt);
	assign pop_end   = m_end || ((m_off == '0) && (cnt_dec == '0));

	assign st_addr   = AW'(cur_q_q) * AW'(QUEUE_DEPTH) + AW'(slot);
	assign id_wide   = {{ITEM_BITS{1'b0}}, item_q};
	assign st_wdata  = id_wide[ITEM_BITS-1:0];

	// queue-state update and memory control
	always_comb begin
		nm_head    = m_head;
		nm_cnt     = m_cnt;
		nm_off     = m_off;
		nm_end     = m_end;
		meta_we    = 1'b0;
		st_we      = 1'b0;
		st_re      = 1'b0;
		meta_re    = 1'b0;
		meta_raddr = cur_q_q + QW'(1);
		case (state_q)
			ST_IDLE: begin
				meta_re    = s_accept;
				meta_raddr = (req_in == REQ_ROUND) ? '0 : qidx_tr;
			end
			ST_META: begin
				if (out_free) begin
					case (req_q)
						REQ_ENQ: begin
							if (!full) begin
								nm_cnt  = cnt_inc;
								meta_we = 1'b1;
								st_we   = 1'b1;
							end
						end
						REQ_REWIND: begin
							nm_off  = '0;
							nm_end  = (m_cnt == '0);
							meta_we = 1'b1;
						end
						REQ_STEP: begin
							if (!m_end) begin
								st_re   = 1'b1;
								nm_off  = step_last ? '0 : m_off + PW'(1);
								nm_end  = step_last;
								meta_we = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			ST_RMETA: begin
				if (m_cnt == '0) begin
					meta_re = !last_queue;
				end else begin
					st_re   = 1'b1;
					nm_head = head_inc;
					nm_cnt  = cnt_dec;
					nm_end  = pop_end;
					if (!m_end && m_off != '0) begin
						nm_off = m_off - PW'(1);
					end
					meta_we = 1'b1;
				end
			end
			ST_RITEM: begin
				meta_re = ritem_go && !last_queue;
			end
			default: ;
		endcase
	end

	// result selection into the output register
	always_comb begin
		out_push = 1'b0;
		op_kind  = KIND_ENQ;
		op_stat  = STAT_OK;
		op_qn    = qidx_q;
		op_item  = '0;
		op_rem   = '0;
		op_hn    = 1'b0;
		op_last  = 1'b1;
		case (state_q)
			ST_BAD: begin
				out_push = out_free;
				op_kind  = kind_t'({1'b0, req_q});
				op_stat  = STAT_BAD_INDEX;
			end
			ST_META: begin
				op_rem = to_rem(m_cnt);
				case (req_q)
					REQ_ENQ: begin
						out_push = out_free;
						op_kind  = KIND_ENQ;
						op_stat  = full ? STAT_NO_ROOM : STAT_OK;
						op_rem   = to_rem(full ? m_cnt : cnt_inc);
						op_hn    = !m_end;
					end
					REQ_REWIND: begin
						out_push = out_free;
						op_kind  = KIND_REWIND;
						op_hn    = (m_cnt != '0);
					end
					REQ_STEP: begin
						out_push = out_free && m_end;
						op_kind  = KIND_CURSOR;
						op_stat  = STAT_NO_ROOM;
					end
					default: ;
				endcase
			end
			ST_STEP: begin
				out_push = out_free;
				op_kind  = KIND_CURSOR;
				op_item  = to_id(st_rdata);
				op_rem   = nx_rem_q;
				op_hn    = nx_hn_q;
			end
			ST_RITEM, ST_REND: begin
				out_push = out_free && (pd_valid_q || state_q == ST_REND);
				op_kind  = pd_valid_q ? KIND_SERVED : KIND_EMPTY;
				op_qn    = pd_valid_q ? pd_qn_q : '0;
				op_item  = pd_valid_q ? pd_item_q : '0;
				op_rem   = pd_valid_q ? pd_rem_q : '0;
				op_hn    = pd_valid_q && pd_hn_q;
				op_last  = (state_q == ST_REND);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			vld_q      <= '0;
			pd_valid_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (meta_we) begin
				vld_q[cur_q_q] <= 1'b1;
			end
			if (out_push) begin
				m_tvalid_q <= 1'b1;
				o_kind_q   <= op_kind;
				o_stat_q   <= op_stat;
				o_qn_q     <= op_qn;
				o_item_q   <= op_item;
				o_rem_q    <= op_rem;
				o_hn_q     <= op_hn;
				o_last_q   <= op_last;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						req_q      <= req_in;
						qidx_q     <= qidx_in;
						item_q     <= s_tdata[QIDX_W+ID_W-1:QIDX_W];
						pd_valid_q <= 1'b0;
						cur_q_q    <= (req_in == REQ_ROUND) ? '0 : qidx_tr;
						if (req_in == REQ_ROUND) begin
							state_q <= ST_RMETA;
						end else if (bad_in) begin
							state_q <= ST_BAD;
						end else begin
							state_q <= ST_META;
						end
					end
				end
				ST_BAD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_META: begin
					if (out_free) begin
						if (req_q == REQ_STEP && !m_end) begin
							nx_rem_q <= to_rem(m_cnt);
							nx_hn_q  <= !step_last;
							state_q  <= ST_STEP;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_STEP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RMETA: begin
					if (m_cnt != '0) begin
						nx_rem_q <= to_rem(cnt_dec);
						nx_hn_q  <= !pop_end;
						state_q  <= ST_RITEM;
					end else if (last_queue) begin
						state_q <= ST_REND;
					end else begin
						cur_q_q <= cur_q_q + QW'(1);
					end
				end
				ST_RITEM: begin
					// hold the popped head until the next one shows whether it is final
					if (ritem_go) begin
						pd_valid_q <= 1'b1;
						pd_qn_q    <= to_qn(cur_q_q);
						pd_item_q  <= to_id(st_rdata);
						pd_rem_q   <= nx_rem_q;
						pd_hn_q    <= nx_hn_q;
						if (last_queue) begin
							state_q <= ST_REND;
						end else begin
							cur_q_q <= cur_q_q + QW'(1);
							state_q <= ST_RMETA;
						end
					end
				end
				ST_REND: begin
					if (out_free) begin
						pd_valid_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	mqf_ram #(
		.WIDTH(MW),
		.DEPTH(NUM_QUEUES)
	) u_meta_ram (
		.clk  (clk),
		.we   (meta_we),
		.waddr(cur_q_q),
		.wdata({nm_head, nm_cnt, nm_off, nm_end}),
		.re   (meta_re),
		.raddr(meta_raddr),
		.rdata(meta_rdata)
	);

	mqf_ram #(
		.WIDTH(ITEM_BITS),
		.DEPTH(SD)
	) u_item_ram (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_addr),
		.wdata(st_wdata),
		.re   (st_re),
		.raddr(st_addr),
		.rdata(st_rdata)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, o_hn_q, o_rem_q, o_item_q, o_qn_q, o_stat_q};
	assign m_tuser  = o_kind_q;
	assign m_tlast  = o_last_q;

`ifndef SYNTHESIS
	a_pend_in_round: assert property (@(posedge clk) disable iff (!arst_n)
		pd_valid_q |-> (state_q == ST_RMETA || state_q == ST_RITEM || state_q == ST_REND))
		else $error("pending served beat outside a service round");

	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(meta_we && !nm_end) |-> (CW'(nm_off) < nm_cnt))
		else $error("live cursor beyond the queued items");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		meta_we |-> (nm_cnt <= CW'(QUEUE_DEPTH)))
		else $error("queue count above depth");

	a_pop_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RITEM) |-> ($past(st_re) || $past(state_q == ST_RITEM)))
		else $error("served item without a store read");
`endif

endmodule

>>> tb/multi_queue_fifo_service_round_test.sv
// ----------------------------------------------------------------------------
// multi_queue_fifo_service_round_test: self-checking bench of the queue bank
// Drives enqueue, rewind, step and service-round requests over the slave
// stream. A behavioral copy of the queues, cursors and store predicts every
// result beat, which is checked field by field on the master stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_queue_fifo_service_round_test;
	import mqf_pkg::*;

	localparam int NQ          = NUM_QUEUES_DEF;
	localparam int DEPTH       = QUEUE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		kind_t             kind;
		stat_t             status;
		logic [QIDX_W-1:0] queue_number;
		logic [ID_W-1:0]   item_out;
		logic [REM_W-1:0]  remaining;
		logic              has_next;
		logic              last;
	} fifo_result_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [REQ_W-1:0]     s_tuser  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [KIND_W-1:0]    m_tuser;
	logic                 m_tlast;

	multi_queue_fifo_service_round dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// queue bank as the block should hold it
	logic [ID_W-1:0] item_mem [NQ][DEPTH];
	int unsigned     head_slot [NQ];
	int unsigned     fill_count [NQ];
	int unsigned     cur_off [NQ];
	bit              cur_done [NQ];

	fifo_result_t    pending_results [$];

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int          error_count    = 0;
	int          n_requests     = 0;
	int          n_results      = 0;
	int          n_served       = 0;
	int          n_full         = 0;
	int          n_no_item      = 0;
	int          n_empty_rounds = 0;
	longint      cycle_count    = 0;

	function automatic fifo_result_t make_result(kind_t k, stat_t st, int unsigned q,
			logic [ID_W-1:0] item, int unsigned rem, bit nxt, bit lst);
		fifo_result_t r;
		r.kind         = k;
		r.status       = st;
		r.queue_number = q[QIDX_W-1:0];
		r.item_out     = item;
		r.remaining    = rem[REM_W-1:0];
		r.has_next     = nxt;
		r.last         = lst;
		return r;
	endfunction

	function automatic void predict_request(req_t req, logic [QIDX_W-1:0] q,
			logic [ID_W-1:0] id);
		fifo_result_t    round_res [NQ];
		int              n;
		int unsigned     qi;
		stat_t           st;
		logic [ID_W-1:0] v;
		n  = 0;
		qi = 32'(q);
		case (req)
			REQ_ROUND: begin
				for (int i = 0; i < NQ; i++) begin
					if (fill_count[i] == 0)
						continue;
					v = item_mem[i][head_slot[i]];
					head_slot[i] = (head_slot[i] + 1) % DEPTH;
					fill_count[i]--;
					// cursor follows the pop: on the head it moves to the new head
					if (!cur_done[i]) begin
						if (cur_off[i] > 0)
							cur_off[i]--;
						else if (fill_count[i] == 0)
							cur_done[i] = 1'b1;
					end
					round_res[n] = make_result(KIND_SERVED, STAT_OK, i, v, fill_count[i],
						!cur_done[i], 1'b0);
					n++;
				end
				if (n == 0) begin
					pending_results.push_back(make_result(KIND_EMPTY, STAT_OK, 0, '0, 0,
						1'b0, 1'b1));
					n_empty_rounds++;
				end else begin
					round_res[n-1].last = 1'b1;
					for (int i = 0; i < n; i++)
						pending_results.push_back(round_res[i]);
					n_served += n;
				end
			end
			REQ_ENQ: begin
				st = STAT_OK;
				if (fill_count[qi] >= DEPTH) begin
					st = STAT_NO_ROOM;
					n_full++;
				end else begin
					item_mem[qi][(head_slot[qi] + fill_count[qi]) % DEPTH] = id;
					fill_count[qi]++;
				end
				pending_results.push_back(make_result(KIND_ENQ, st, qi, '0, fill_count[qi],
					!cur_done[qi], 1'b1));
			end
			REQ_REWIND: begin
				cur_off[qi]  = 0;
				cur_done[qi] = (fill_count[qi] == 0);
				pending_results.push_back(make_result(KIND_REWIND, STAT_OK, qi, '0,
					fill_count[qi], !cur_done[qi], 1'b1));
			end
			default: begin
				if (cur_done[qi]) begin
					n_no_item++;
					pending_results.push_back(make_result(KIND_CURSOR, STAT_NO_ROOM, qi, '0,
						fill_count[qi], 1'b0, 1'b1));
				end else begin
					v = item_mem[qi][(head_slot[qi] + cur_off[qi]) % DEPTH];
					cur_off[qi]++;
					if (cur_off[qi] >= fill_count[qi]) begin
						cur_done[qi] = 1'b1;
						cur_off[qi]  = 0;
					end
					pending_results.push_back(make_result(KIND_CURSOR, STAT_OK, qi, v,
						fill_count[qi], !cur_done[qi], 1'b1));
				end
			end
		endcase
	endfunction

	// valid stays high between back-to-back beats; it only drops inside a gap
	task automatic send_request(req_t req, logic [QIDX_W-1:0] q, logic [ID_W-1:0] id);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {4'b0, id, q};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_request(req, q, id);
		n_requests++;
	endtask

	task automatic report_field(string name, int unsigned want, int unsigned got);
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		error_count++;
	endtask

	always @(posedge clk) begin : result_check
		fifo_result_t got;
		fifo_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind         = kind_t'(m_tuser);
			got.status       = stat_t'(m_tdata[1:0]);
			got.queue_number = m_tdata[5:2];
			got.item_out     = m_tdata[21:6];
			got.remaining    = m_tdata[28:22];
			got.has_next     = m_tdata[29];
			got.last         = m_tlast;
			n_results++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual kind %0d queue %0d item %0h",
					$time, got.kind, got.queue_number, got.item_out);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.kind !== want.kind)
					report_field("result_kind", want.kind, got.kind);
				if (got.status !== want.status)
					report_field("status", want.status, got.status);
				if (got.queue_number !== want.queue_number)
					report_field("queue_number", want.queue_number, got.queue_number);
				if (got.item_out !== want.item_out)
					report_field("item_out", want.item_out, got.item_out);
				if (got.remaining !== want.remaining)
					report_field("remaining", want.remaining, got.remaining);
				if (got.has_next !== want.has_next)
					report_field("has_next", want.has_next, got.has_next);
				if (got.last !== want.last)
					report_field("last", want.last, got.last);
			end
		end
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still pending", $time, pending_results.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic test_directed();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_request(REQ_ROUND, 4'd0, 16'h0000);   // nothing queued: empty round
		send_request(REQ_STEP, 4'd0, 16'h0000);    // no cursor yet
		send_request(REQ_REWIND, 4'd0, 16'h0000);  // empty queue: cursor ends at once
		send_request(REQ_ENQ, 4'd0, 16'h0000);
		send_request(REQ_ENQ, 4'd0, 16'hFFFF);
		send_request(REQ_ENQ, 4'd15, 16'hA5A5);
		send_request(REQ_STEP, 4'd0, 16'h0000);    // still ended after arrivals
		send_request(REQ_REWIND, 4'd0, 16'h0000);
		send_request(REQ_STEP, 4'd0, 16'h0000);
		send_request(REQ_STEP, 4'd0, 16'h0000);    // lands on the tail, ends
		send_request(REQ_ENQ, 4'd0, 16'h1234);
		send_request(REQ_STEP, 4'd0, 16'h0000);    // appended item not reached
		send_request(REQ_REWIND, 4'd15, 16'hFFFF);
		send_request(REQ_REWIND, 4'd0, 16'h0000);
		send_request(REQ_STEP, 4'd0, 16'h0000);    // cursor one behind head
		send_request(REQ_ROUND, 4'd15, 16'hFFFF);  // q15 empties under its cursor
		send_request(REQ_STEP, 4'd0, 16'h0000);
		send_request(REQ_REWIND, 4'd0, 16'h0000);  // cursor on head, then popped
		send_request(REQ_ROUND, 4'd0, 16'h0000);
		send_request(REQ_ROUND, 4'd0, 16'h0000);
		send_request(REQ_ROUND, 4'd0, 16'h0000);
		send_request(REQ_ENQ, 4'd7, 16'h5A5A);
		send_request(REQ_STEP, 4'd7, 16'h0000);
	endtask

	task automatic test_full_queue();
		send_idle_pct  = 64;
		recv_stall_pct = 0;
		for (int i = 0; i < DEPTH + 2; i++)
			send_request(REQ_ENQ, 4'd9, 16'($urandom));
		send_request(REQ_REWIND, 4'd9, 16'h0000);
		repeat (3)
			send_request(REQ_STEP, 4'd9, 16'h0000);
		send_request(REQ_ROUND, 4'd0, 16'h0000);
		send_request(REQ_ENQ, 4'd9, 16'hBEEF);     // one slot free again
		send_request(REQ_ENQ, 4'd9, 16'hCAFE);     // full again
	endtask

	task automatic test_random(int unsigned count, int unsigned idle, int unsigned stall);
		int unsigned       pick;
		req_t              req;
		logic [QIDX_W-1:0] q;
		send_idle_pct  = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				req = REQ_ENQ;
			else if (pick < 60)
				req = REQ_REWIND;
			else if (pick < 85)
				req = REQ_STEP;
			else
				req = REQ_ROUND;
			// bias toward a few queues so they grow deep enough for stepping
			if ($urandom_range(0, 1) == 0)
				q = 4'($urandom_range(0, NQ - 1));
			else
				q = 4'($urandom_range(0, 3));
			send_request(req, q, 16'($urandom));
		end
	endtask

	task automatic drain_and_report();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40)
			@(posedge clk);
		$display("Ran %0d requests and checked %0d result beats: %0d served items,",
			n_requests, n_results, n_served);
		$display("%0d full-queue rejects, %0d steps without item, %0d empty rounds.",
			n_full, n_no_item, n_empty_rounds);
		if (error_count == 0 && pending_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	endtask

	initial begin
		for (int i = 0; i < NQ; i++) begin
			head_slot[i]  = 0;
			fill_count[i] = 0;
			cur_off[i]    = 0;
			cur_done[i]   = 1'b1;
		end
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_queue();
		test_random(64, 0, 0);
		test_random(64, 64, 0);
		test_random(64, 0, 64);
		test_random(62, 25, 25);
		drain_and_report();
	end

endmodule
